FILE: hw/rtl/delay_budget_queue_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delay budget queue classifier
// Clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DELAY_BUDGET_QUEUE_CLASSIFIER_CORE_MACROS_SVH
`define DELAY_BUDGET_QUEUE_CLASSIFIER_CORE_MACROS_SVH

// property that holds at every edge
`define DBQC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define DBQC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dbqc_pkg.sv
// ----------------------------------------------------------------------------
// Delay budget queue classifier package
// Sizes, register indexes, controller states and command/status words
// ----------------------------------------------------------------------------
`default_nettype none

package dbqc_pkg;

  localparam int unsigned MAX_QUEUES   = 16;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned QIDX_W       = 4;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned IDX_BITS     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int unsigned CNT_BITS     = $clog2(MAX_QUEUES + 1);
  localparam int unsigned DIV_CNT_BITS = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;
  localparam int unsigned CMP_W        = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [CNT_BITS-1:0]  count_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DELTA_STEP    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAXIMUM_DELTA = 1'd1;

  localparam field_t DELTA_STEP_RST    = FIELD_W'(1000);
  localparam field_t MAXIMUM_DELTA_RST = FIELD_W'(1000000);

  localparam count_t FULL_COUNT = CNT_BITS'(MAX_QUEUES);
  localparam count_t CNT_ONE    = CNT_BITS'(1);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(TIME_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ROUND_SUB,
    ST_ROUND_ADD,
    ST_SEARCH,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic prep;
    logic div_step;
    logic round_sub;
    logic round_add;
    logic search_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic quantize;
    logic div_last;
    logic search_stop;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dbqc_in_if.sv
// ----------------------------------------------------------------------------
// Packet word channel
// Budget bounds and flags of one packet, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dbqc_in_if;
  logic                         valid;
  logic                         ready;
  logic [dbqc_pkg::FIELD_W-1:0] budget_max;
  logic [dbqc_pkg::FIELD_W-1:0] budget_min;
  logic                         tag_present;
  logic                         infinite_deadline;

  modport source (
    output valid, budget_max, budget_min, tag_present, infinite_deadline,
    input  ready
  );
  modport sink (
    input  valid, budget_max, budget_min, tag_present, infinite_deadline,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dbqc_out_if.sv
// ----------------------------------------------------------------------------
// Classification word channel
// Queue index, class delta and table flags, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dbqc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dbqc_pkg::QIDX_W-1:0]  queue_index;
  logic [dbqc_pkg::FIELD_W-1:0] class_delta;
  logic                         new_queue;
  logic                         table_full;

  modport source (
    output valid, queue_index, class_delta, new_queue, table_full,
    input  ready
  );
  modport sink (
    input  valid, queue_index, class_delta, new_queue, table_full,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dbqc_ctrl.sv
// ----------------------------------------------------------------------------
// Delay budget queue classifier controller
// Sequences accept, remainder division, rounding, table search and commit
// ----------------------------------------------------------------------------
`default_nettype none

module dbqc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dbqc_pkg::dp_status_t status_i,
  output dbqc_pkg::dp_cmd_t    cmd_o
);

  dbqc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbqc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbqc_pkg::ST_IDLE: begin
        if (status_i.in_valid) state_d = dbqc_pkg::ST_PREP;
      end
      dbqc_pkg::ST_PREP: begin
        state_d = status_i.quantize ? dbqc_pkg::ST_DIV : dbqc_pkg::ST_SEARCH;
      end
      dbqc_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = dbqc_pkg::ST_ROUND_SUB;
      end
      dbqc_pkg::ST_ROUND_SUB: begin
        state_d = dbqc_pkg::ST_ROUND_ADD;
      end
      dbqc_pkg::ST_ROUND_ADD: begin
        state_d = dbqc_pkg::ST_SEARCH;
      end
      dbqc_pkg::ST_SEARCH: begin
        if (status_i.search_stop) state_d = dbqc_pkg::ST_COMMIT;
      end
      dbqc_pkg::ST_COMMIT: begin
        if (status_i.out_free) state_d = dbqc_pkg::ST_IDLE;
      end
      default: begin
        state_d = dbqc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      dbqc_pkg::ST_IDLE:      cmd_o.in_ready    = 1'b1;
      dbqc_pkg::ST_PREP:      cmd_o.prep        = 1'b1;
      dbqc_pkg::ST_DIV:       cmd_o.div_step    = 1'b1;
      dbqc_pkg::ST_ROUND_SUB: cmd_o.round_sub   = 1'b1;
      dbqc_pkg::ST_ROUND_ADD: cmd_o.round_add   = 1'b1;
      dbqc_pkg::ST_SEARCH:    cmd_o.search_step = !status_i.search_stop;
      dbqc_pkg::ST_COMMIT:    cmd_o.commit      = status_i.out_free;
      default:                cmd_o             = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dbqc_datapath.sv
// ----------------------------------------------------------------------------
// Delay budget queue classifier datapath
// Config registers, budget, bit-serial remainder, delta table, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "delay_budget_queue_classifier_core_macros.svh"

module dbqc_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [dbqc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire [dbqc_pkg::FIELD_W-1:0]        cfg_wdata_i,
  input  dbqc_pkg::dp_cmd_t                  cmd_i,
  output dbqc_pkg::dp_status_t               status_o,
  dbqc_in_if.sink                            in_i,
  dbqc_out_if.source                         out_o
);

  // configuration
  dbqc_pkg::field_t step_q, max_q;

  // per packet
  dbqc_pkg::time_t                     budget_q, budget_d;
  logic                                tag_q, inf_q;
  dbqc_pkg::time_t                     dvd_q, dvd_d;
  dbqc_pkg::time_t                     rem_q, rem_d;
  logic [dbqc_pkg::DIV_CNT_BITS-1:0]   div_cnt_q, div_cnt_d;
  dbqc_pkg::time_t                     delta_q, delta_d;
  dbqc_pkg::count_t                    idx_q, idx_d;

  // table
  dbqc_pkg::count_t                    used_q, used_d;
  dbqc_pkg::time_t                     table_q [dbqc_pkg::MAX_QUEUES];

  // result register
  logic                                out_valid_q, out_valid_d;
  logic [dbqc_pkg::QIDX_W-1:0]         out_idx_q;
  dbqc_pkg::field_t                    out_delta_q;
  logic                                out_new_q, out_full_q;

  dbqc_pkg::time_t                     bmax, bmin, step_t, eff_step, add_val;
  logic [dbqc_pkg::TIME_BITS:0]        rem_sh, sum;
  logic                                in_acc, out_free, quantize;
  logic                                in_range, match, commit_hit, commit_full, commit_new;

  assign bmax     = dbqc_pkg::time_t'(in_i.budget_max);
  assign bmin     = dbqc_pkg::time_t'(in_i.budget_min);
  assign step_t   = dbqc_pkg::time_t'(step_q);
  assign eff_step = (step_t == '0) ? dbqc_pkg::time_t'(1) : step_t;

  assign in_acc   = in_i.valid && cmd_i.in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign quantize = tag_q && !inf_q &&
                    (dbqc_pkg::CMP_W'(budget_q) < dbqc_pkg::CMP_W'(max_q));

  assign rem_sh   = {rem_q, dvd_q[dbqc_pkg::TIME_BITS-1]};
  assign add_val  = ((rem_q != '0) || (delta_q == '0)) ? eff_step : '0;
  assign sum      = {1'b0, delta_q} + {1'b0, add_val};

  assign in_range    = idx_q < used_q;
  assign match       = in_range && (table_q[idx_q[dbqc_pkg::IDX_BITS-1:0]] == delta_q);
  assign commit_hit  = idx_q != used_q;
  assign commit_full = !commit_hit && (used_q == dbqc_pkg::FULL_COUNT);
  assign commit_new  = !commit_hit && !commit_full;

  assign status_o.in_valid    = in_i.valid;
  assign status_o.quantize    = quantize;
  assign status_o.div_last    = div_cnt_q == dbqc_pkg::DIV_LAST;
  assign status_o.search_stop = match || !in_range;
  assign status_o.out_free    = out_free;

  assign in_i.ready        = cmd_i.in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.queue_index = out_idx_q;
  assign out_o.class_delta = out_delta_q;
  assign out_o.new_queue   = out_new_q;
  assign out_o.table_full  = out_full_q;

  always_comb begin
    budget_d    = budget_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    delta_d     = delta_q;
    idx_d       = idx_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (in_acc) begin
      budget_d = (bmax >= bmin) ? (bmax - bmin) : (bmin - bmax);
    end
    if (cmd_i.prep) begin
      dvd_d     = budget_q;
      rem_d     = '0;
      div_cnt_d = '0;
      delta_d   = dbqc_pkg::time_t'(max_q);
      idx_d     = '0;
    end
    if (cmd_i.div_step) begin
      rem_d     = (rem_sh >= {1'b0, eff_step}) ?
                  dbqc_pkg::TIME_BITS'(rem_sh - {1'b0, eff_step}) :
                  rem_sh[dbqc_pkg::TIME_BITS-1:0];
      dvd_d     = {dvd_q[dbqc_pkg::TIME_BITS-2:0], 1'b0};
      div_cnt_d = div_cnt_q + dbqc_pkg::DIV_CNT_BITS'(1);
    end
    if (cmd_i.round_sub) begin
      delta_d = budget_q - rem_q;
    end
    if (cmd_i.round_add) begin
      delta_d = sum[dbqc_pkg::TIME_BITS] ? '1 : sum[dbqc_pkg::TIME_BITS-1:0];
    end
    if (cmd_i.search_step) begin
      idx_d = idx_q + dbqc_pkg::CNT_ONE;
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (commit_new) used_d = used_q + dbqc_pkg::CNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= dbqc_pkg::DELTA_STEP_RST;
      max_q       <= dbqc_pkg::MAXIMUM_DELTA_RST;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dbqc_pkg::CFG_DELTA_STEP:    step_q <= cfg_wdata_i;
          dbqc_pkg::CFG_MAXIMUM_DELTA: max_q  <= cfg_wdata_i;
          default:                     step_q <= step_q;
        endcase
      end
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    budget_q  <= budget_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    delta_q   <= delta_d;
    idx_q     <= idx_d;
    if (in_acc) begin
      tag_q <= in_i.tag_present;
      inf_q <= in_i.infinite_deadline;
    end
    if (cmd_i.commit) begin
      if (commit_new) table_q[used_q[dbqc_pkg::IDX_BITS-1:0]] <= delta_q;
      out_idx_q   <= commit_full ? '0 : dbqc_pkg::QIDX_W'(idx_q);
      out_delta_q <= dbqc_pkg::FIELD_W'(delta_q);
      out_new_q   <= commit_new;
      out_full_q  <= commit_full;
    end
  end

  `DBQC_ASSERT(a_used_bound, used_q <= dbqc_pkg::FULL_COUNT, "entry count beyond table size")
  `DBQC_ASSERT(a_flag_excl, !(out_valid_q && out_new_q && out_full_q), "new and full both set")
  `DBQC_ASSERT_NEXT(a_full_zero, cmd_i.commit && commit_full, out_full_q && (out_idx_q == '0), "full word without index zero")
  `DBQC_ASSERT_NEXT(a_alloc_count, cmd_i.commit && commit_new, used_q == $past(used_q) + dbqc_pkg::CNT_ONE, "allocation did not bump count")

endmodule

`default_nettype wire

FILE: hw/rtl/delay_budget_queue_classifier_core.sv
// ----------------------------------------------------------------------------
// Delay budget queue classifier core
// Quantises a packet's delay budget and maps the class delta to a queue index
//
//   port    dir   word
//   in_i    sink  budget_max, budget_min, tag_present, infinite_deadline
//   out_o   src   queue_index, class_delta, new_queue, table_full
//   cfg_*   in    delta_step (0), maximum_delta (1), write only
//
// one packet at a time: accept, prep and, when the budget is rounded, the 32-step
// bit-serial remainder and the rounding subtract and add, then the one-entry-per-cycle
// table scan over up to 16 entries, then a commit that waits for a free result register
// a finished word sits in the result register while the next packet is taken
// reset clears the controller, entry count and result valid; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module delay_budget_queue_classifier_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [dbqc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire [dbqc_pkg::FIELD_W-1:0]      cfg_wdata_i,
  dbqc_in_if.sink                          in_i,
  dbqc_out_if.source                       out_o
);

  dbqc_pkg::dp_cmd_t    cmd;
  dbqc_pkg::dp_status_t status;

  dbqc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dbqc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
